@@ rtl/stq_pkg.sv @@
`default_nettype none
package stq_pkg;

  localparam int unsigned SlotsDef = 16;
  localparam int unsigned SlotW = 4;
  localparam int unsigned TimeW = 32;
  localparam int unsigned MaxExpire = 16;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_CANCEL = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_QUEUED = 2'd1,
    ST_NOTQ   = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TICK_RD,
    S_TICK_CHK,
    S_TICK_OUT,
    S_ADD_RD,
    S_ADD_CHK,
    S_ADD_SHIFT,
    S_CAN_RD,
    S_CAN_CHK,
    S_CAN_SHIFT,
    S_ACK
  } state_e;

  typedef struct packed {
    logic       latch_in;
    logic       tick_time;
    logic       pos_clr;
    logic       pos_inc;
    logic       pos_dec;
    logic       pos_to_len;
    logic       shift_up;
    logic       shift_down;
    logic       insert;
    logic       len_inc;
    logic       len_dec;
    logic       clr_flag;
    logic       set_flag;
    logic       load_res;
    logic       res_expiry;
    logic [1:0] res_status;
    logic       res_last;
    logic       cnt_clr;
    logic       cnt_inc;
  } stq_cmd_t;

  typedef struct packed {
    logic [1:0] in_cmd;
    logic [1:0] cmd;
    logic       slot_ok;
    logic       queued;
    logic       pos_lt_len;
    logic       pos_at_end;
    logic       len_zero;
    logic       head_due;
    logic       next_due;
    logic       entry_le;
    logic       entry_match;
    logic       cnt_max;
    logic       cnt_zero;
    logic       res_busy;
  } stq_stat_t;

endpackage
`default_nettype wire

@@ rtl/sorted_timeout_queue.sv @@
// Deadline-sorted millisecond timer queue.
// Slave channel s_axis_*: one command per transfer (tick, add, cancel).
// Master channel m_axis_*: results. Add and cancel give one acknowledge;
// a tick gives one expiry per due slot (at most 16), in deadline order,
// with equal deadlines in the order they were added; tlast marks the
// final result of a command. A tick with nothing due gives no result.
// One command is processed at a time. For each expiry a tick compares
// the head deadline, loads the result, then compacts the list. An add
// walks the sorted list entry by entry, then shifts the tail one entry
// a cycle. A cancel searches and compacts the list.
// Results go through one output register; while the receiver stalls the
// block holds before loading its next result, so the input stalls once
// a further command that gives a result has been accepted.
// Reset clears the time, queue length and queued flags; deadline, tag and
// order storage is left as is and read only after being written.
`default_nettype none
module sorted_timeout_queue #(
  parameter int unsigned SLOTS = stq_pkg::SlotsDef
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [71:0] s_axis_tdata,  // cmd[1:0], slot[5:2], delay_ms[37:6], tag[69:38]
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [39:0] m_axis_tdata,  // out_slot[3:0], out_tag[35:4], status[37:36]
  output logic        m_axis_tuser,  // kind
  output logic        m_axis_tlast
);

  stq_pkg::stq_cmd_t  ctl;
  stq_pkg::stq_stat_t stat;
  logic [3:0]  res_slot;
  logic [31:0] res_tag;
  logic [1:0]  res_status;

  stq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (ctl)
  );

  stq_dp #(.Slots(SLOTS)) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (s_axis_tdata[1:0]),
    .slot_i       (s_axis_tdata[5:2]),
    .delay_i      (s_axis_tdata[37:6]),
    .tag_i        (s_axis_tdata[69:38]),
    .ctl_i        (ctl),
    .stat_o       (stat),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_kind_o   (m_axis_tuser),
    .res_slot_o   (res_slot),
    .res_tag_o    (res_tag),
    .res_status_o (res_status),
    .res_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, res_status, res_tag, res_slot};

endmodule
`default_nettype wire

@@ rtl/stq_ctrl.sv @@
`default_nettype none
module stq_ctrl (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  stq_pkg::stq_stat_t stat_i,
  output stq_pkg::stq_cmd_t  cmd_o
);

  stq_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= stq_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      stq_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          cmd_o.pos_clr = 1'b1;
          cmd_o.cnt_clr = 1'b1;
          state_d = stq_pkg::S_ACK;
          case (stat_i.in_cmd)
            stq_pkg::CMD_TICK:   state_d = stq_pkg::S_TICK_RD;
            stq_pkg::CMD_ADD:    state_d = stq_pkg::S_ADD_RD;
            stq_pkg::CMD_CANCEL: state_d = stq_pkg::S_CAN_RD;
            default:             state_d = stq_pkg::S_IDLE;
          endcase
          if (stat_i.in_cmd == stq_pkg::CMD_TICK) cmd_o.tick_time = 1'b1;
        end
      end
      stq_pkg::S_TICK_RD: begin
        state_d = stq_pkg::S_TICK_CHK;
      end
      stq_pkg::S_TICK_CHK: begin
        if (stat_i.len_zero || !stat_i.head_due) begin
          state_d = stq_pkg::S_IDLE;
        end else begin
          state_d = stq_pkg::S_TICK_OUT;
        end
      end
      stq_pkg::S_TICK_OUT: begin
        if (!stat_i.res_busy) begin
          cmd_o.load_res = 1'b1;
          cmd_o.res_expiry = 1'b1;
          cmd_o.res_last = stat_i.cnt_max || !stat_i.next_due;
          cmd_o.clr_flag = 1'b1;
          cmd_o.len_dec = 1'b1;
          cmd_o.pos_clr = 1'b1;
          cmd_o.cnt_inc = 1'b1;
          state_d = stq_pkg::S_CAN_SHIFT;
        end
      end
      stq_pkg::S_ADD_RD: begin
        if (!stat_i.slot_ok) begin
          cmd_o.res_status = stq_pkg::ST_NOTQ;
          state_d = stq_pkg::S_ACK;
        end else if (stat_i.queued) begin
          cmd_o.res_status = stq_pkg::ST_QUEUED;
          state_d = stq_pkg::S_ACK;
        end else if (!stat_i.pos_lt_len) begin
          cmd_o.pos_to_len = 1'b1;
          state_d = stq_pkg::S_ADD_SHIFT;
        end else begin
          state_d = stq_pkg::S_ADD_CHK;
        end
      end
      stq_pkg::S_ADD_CHK: begin
        if (stat_i.entry_le) begin
          cmd_o.pos_inc = 1'b1;
          state_d = stq_pkg::S_ADD_RD;
        end else begin
          cmd_o.pos_to_len = 1'b1;
          state_d = stq_pkg::S_ADD_SHIFT;
        end
      end
      stq_pkg::S_ADD_SHIFT: begin
        if (stat_i.pos_at_end) begin
          cmd_o.insert = 1'b1;
          cmd_o.set_flag = 1'b1;
          cmd_o.len_inc = 1'b1;
          state_d = stq_pkg::S_ACK;
        end else begin
          cmd_o.shift_up = 1'b1;
          cmd_o.pos_dec = 1'b1;
        end
      end
      stq_pkg::S_CAN_RD: begin
        if (!stat_i.slot_ok || !stat_i.queued) begin
          cmd_o.res_status = stq_pkg::ST_NOTQ;
          state_d = stq_pkg::S_ACK;
        end else begin
          state_d = stq_pkg::S_CAN_CHK;
        end
      end
      stq_pkg::S_CAN_CHK: begin
        if (stat_i.entry_match) begin
          cmd_o.clr_flag = 1'b1;
          cmd_o.len_dec = 1'b1;
          state_d = stq_pkg::S_CAN_SHIFT;
        end else begin
          cmd_o.pos_inc = 1'b1;
          state_d = stq_pkg::S_CAN_RD;
        end
      end
      stq_pkg::S_CAN_SHIFT: begin
        if (stat_i.pos_lt_len) begin
          cmd_o.shift_down = 1'b1;
          cmd_o.pos_inc = 1'b1;
        end else if (stat_i.cmd == stq_pkg::CMD_TICK) begin
          cmd_o.pos_clr = 1'b1;
          state_d = stat_i.cnt_zero ? stq_pkg::S_IDLE : stq_pkg::S_TICK_RD;
        end else begin
          state_d = stq_pkg::S_ACK;
        end
      end
      stq_pkg::S_ACK: begin
        if (!stat_i.res_busy) begin
          cmd_o.load_res = 1'b1;
          cmd_o.res_last = 1'b1;
          state_d = stq_pkg::S_IDLE;
        end
      end
      default: state_d = stq_pkg::S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/stq_dp.sv @@
`default_nettype none
module stq_dp #(
  parameter int unsigned Slots = stq_pkg::SlotsDef
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire  [1:0]                 cmd_i,
  input  wire  [stq_pkg::SlotW-1:0]  slot_i,
  input  wire  [stq_pkg::TimeW-1:0]  delay_i,
  input  wire  [stq_pkg::TimeW-1:0]  tag_i,
  input  stq_pkg::stq_cmd_t          ctl_i,
  output stq_pkg::stq_stat_t         stat_o,
  output logic                       res_valid_o,
  input  wire                        res_ready_i,
  output logic                       res_kind_o,
  output logic [stq_pkg::SlotW-1:0]  res_slot_o,
  output logic [stq_pkg::TimeW-1:0]  res_tag_o,
  output logic [1:0]                 res_status_o,
  output logic                       res_last_o
);

  localparam int unsigned IdxW = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int unsigned LenW = $clog2(Slots + 1);
  localparam int unsigned CntW = $clog2(stq_pkg::MaxExpire);

  logic [stq_pkg::TimeW-1:0] now_q;
  logic [Slots-1:0]          queued_q;
  logic [LenW-1:0]           len_q;
  logic [LenW-1:0]           pos_q;
  logic [CntW-1:0]           cnt_q;
  logic [1:0]                cmd_q;
  logic [1:0]                st_q;
  logic [stq_pkg::SlotW-1:0] slot_q;
  logic [stq_pkg::TimeW-1:0] dl_q;
  logic [stq_pkg::TimeW-1:0] tag_q;
  logic [IdxW-1:0]           order_q [Slots];
  logic [stq_pkg::TimeW-1:0] dl_mem_q [Slots];
  logic [stq_pkg::TimeW-1:0] tag_mem_q [Slots];
  logic [IdxW-1:0]           ent_q;
  logic [IdxW-1:0]           pos_idx;
  logic [IdxW-1:0]           slot_idx;
  logic [IdxW-1:0]           tgt_idx;
  logic                      slot_ok;

  function automatic logic order_pos_ok(input logic [LenW-1:0] p, input logic [LenW-1:0] l);
    order_pos_ok = (p != '0) && (p <= l);
  endfunction

  assign pos_idx = pos_q[IdxW-1:0];
  assign slot_ok = ({{(32-stq_pkg::SlotW){1'b0}}, slot_q} < 32'(Slots));
  assign slot_idx = IdxW'(slot_q);
  assign tgt_idx = (cmd_q == stq_pkg::CMD_TICK) ? order_q[0] : slot_idx;

  always_ff @(posedge clk_i) begin
    ent_q <= order_q[pos_idx];
    if (ctl_i.latch_in) begin
      slot_q <= slot_i;
      tag_q <= tag_i;
      dl_q <= now_q + delay_i + stq_pkg::TimeW'(1);
    end
    if (ctl_i.insert) begin
      order_q[pos_idx] <= slot_idx;
      dl_mem_q[slot_idx] <= dl_q;
      tag_mem_q[slot_idx] <= tag_q;
    end
    for (int i = 1; i < Slots; i++) begin
      if (ctl_i.shift_up && pos_idx == IdxW'(i)) order_q[i] <= order_q[i-1];
    end
    for (int i = 0; i < Slots - 1; i++) begin
      if (ctl_i.shift_down && pos_idx == IdxW'(i)) order_q[i] <= order_q[i+1];
    end
    if (ctl_i.load_res) begin
      res_kind_o <= ctl_i.res_expiry;
      res_slot_o <= ctl_i.res_expiry ? stq_pkg::SlotW'(order_q[0]) : slot_q;
      res_tag_o <= ctl_i.res_expiry ? tag_mem_q[order_q[0]] : '0;
      res_last_o <= ctl_i.res_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q <= '0;
      queued_q <= '0;
      len_q <= '0;
      pos_q <= '0;
      cnt_q <= '0;
      cmd_q <= stq_pkg::CMD_NONE;
      st_q <= stq_pkg::ST_OK;
      res_valid_o <= 1'b0;
      res_status_o <= stq_pkg::ST_OK;
    end else begin
      if (ctl_i.latch_in) cmd_q <= cmd_i;
      if (ctl_i.tick_time) now_q <= now_q + stq_pkg::TimeW'(1);
      if (ctl_i.pos_clr) begin
        pos_q <= '0;
      end else if (ctl_i.pos_to_len) begin
        pos_q <= len_q;
      end else if (ctl_i.pos_inc) begin
        pos_q <= pos_q + LenW'(1);
      end else if (ctl_i.pos_dec) begin
        pos_q <= pos_q - LenW'(1);
      end
      if (ctl_i.cnt_clr) begin
        cnt_q <= '0;
      end else if (ctl_i.cnt_inc) begin
        cnt_q <= cnt_q + CntW'(1);
      end
      if (ctl_i.len_inc) len_q <= len_q + LenW'(1);
      if (ctl_i.len_dec) len_q <= len_q - LenW'(1);
      if (ctl_i.set_flag) queued_q[slot_idx] <= 1'b1;
      if (ctl_i.clr_flag) queued_q[tgt_idx] <= 1'b0;
      if (ctl_i.latch_in) st_q <= stq_pkg::ST_OK;
      if (ctl_i.res_status != stq_pkg::ST_OK) st_q <= ctl_i.res_status;
      if (ctl_i.load_res) begin
        res_valid_o <= 1'b1;
        res_status_o <= ctl_i.res_expiry ? stq_pkg::ST_OK : st_q;
      end else if (res_ready_i) begin
        res_valid_o <= 1'b0;
      end
    end
  end

  always_comb begin
    stat_o = '0;
    stat_o.in_cmd = cmd_i;
    stat_o.cmd = cmd_q;
    stat_o.slot_ok = slot_ok;
    stat_o.queued = queued_q[slot_idx];
    stat_o.pos_lt_len = (pos_q < len_q) &&
                        ((cmd_q != stq_pkg::CMD_ADD) || (pos_q < LenW'(Slots)));
    stat_o.pos_at_end = (pos_q == '0) || (order_pos_ok(pos_q, len_q) &&
                        (dl_mem_q[order_q[pos_idx - IdxW'(1)]] <= dl_q));
    stat_o.len_zero = (len_q == '0);
    stat_o.head_due = (dl_mem_q[order_q[0]] <= now_q);
    stat_o.next_due = (len_q > LenW'(1)) && (dl_mem_q[order_q[1]] <= now_q);
    stat_o.entry_le = (dl_mem_q[ent_q] <= dl_q);
    stat_o.entry_match = (ent_q == slot_idx);
    stat_o.cnt_max = (cnt_q == CntW'(stq_pkg::MaxExpire - 1));
    stat_o.cnt_zero = (cnt_q == '0);
    stat_o.res_busy = res_valid_o && !res_ready_i;
  end

endmodule
`default_nettype wire
